/* hdl/keyframe_gated_frame_queue_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the key-frame gated frame queue
// Shared concurrent assertion forms, clocked on rising edge, masked in reset.
// ---------------------------------------------------------------------------
`ifndef KEYFRAME_GATED_FRAME_QUEUE_UNIT_MACROS_SVH
`define KEYFRAME_GATED_FRAME_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define KGFQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kgfq assertion failed");

// next-cycle implication
`define KGFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kgfq assertion failed");

`endif

/* hdl/kgfq_pkg.sv */
// ---------------------------------------------------------------------------
// kgfq_pkg
// Widths, operation codes, register indices and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package kgfq_pkg;

  localparam int DEPTH      = 16;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  localparam int KIND_W     = 2;
  localparam int HANDLE_W   = 32;
  localparam int FLAGS_W    = 8;
  localparam int TIME_W     = 64;
  localparam int DROP_W     = 5;
  localparam int ENTRY_W    = HANDLE_W + TIME_W;

  localparam int IN_DATA_W  = HANDLE_W + FLAGS_W + TIME_W;
  localparam int OUT_DATA_W = 1 + DROP_W + 1 + 1 + HANDLE_W + TIME_W;

  localparam int LIMIT_W    = 5;
  localparam int AGE_W      = 32;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(16);
  localparam logic [AGE_W-1:0]   AGE_RST   = AGE_W'(100000);

  localparam logic [CFG_ADDR_W-1:0] REG_QUEUE_LIMIT = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_AGE     = CFG_ADDR_W'(1);

  localparam logic [KIND_W-1:0] KIND_ENQUEUE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP_KEY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESET    = 2'd3;

  typedef struct packed {
    logic               we;
    logic [PTR_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [PTR_W-1:0]   raddr;
  } ram_req_t;

endpackage

`default_nettype wire

/* hdl/kgfq_store_ram.sv */
// ---------------------------------------------------------------------------
// kgfq_store_ram
// Simple dual-port entry store, one write and one registered read a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module kgfq_store_ram #(
  parameter int WIDTH  = 96,
  parameter int DEPTH_P = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH_P)-1:0] waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH_P)-1:0] raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/kgfq_ctrl.sv */
// ---------------------------------------------------------------------------
// kgfq_ctrl
// Operation sequencer: read oldest entry, decide, write back, drive result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "keyframe_gated_frame_queue_unit_macros.svh"

module kgfq_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [kgfq_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic [kgfq_pkg::KIND_W-1:0]      in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [kgfq_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  wire logic [kgfq_pkg::LIMIT_W-1:0]     queue_limit,
  input  wire logic [kgfq_pkg::AGE_W-1:0]       max_age_us,
  output kgfq_pkg::ram_req_t                    ram_req,
  input  wire logic [kgfq_pkg::ENTRY_W-1:0]     ram_rdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EX   = 2'd2;

  logic [1:0]                        state_r, state_nxt;
  logic [kgfq_pkg::KIND_W-1:0]       kind_r;
  logic [kgfq_pkg::HANDLE_W-1:0]     handle_r;
  logic                              key_r;
  logic [kgfq_pkg::TIME_W-1:0]       now_r;
  logic [kgfq_pkg::PTR_W-1:0]        head_r, head_nxt;
  logic [kgfq_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                              wait_r, wait_nxt;
  logic                              out_valid_r;
  logic [kgfq_pkg::OUT_DATA_W-1:0]   out_data_r;

  logic                              in_fire;
  logic                              ex_fire;
  logic [kgfq_pkg::CNT_W-1:0]        cap;
  logic [kgfq_pkg::HANDLE_W-1:0]     rd_handle;
  logic [kgfq_pkg::TIME_W-1:0]       rd_time;
  logic [kgfq_pkg::TIME_W-1:0]       age;
  logic                              aged;
  logic [kgfq_pkg::SUM_W-1:0]        slot_sum;
  logic [kgfq_pkg::PTR_W-1:0]        slot;
  logic                              push;
  logic                              res_acc;
  logic [kgfq_pkg::DROP_W-1:0]       res_drop;
  logic                              res_disc;
  logic                              res_pvalid;
  logic [kgfq_pkg::HANDLE_W-1:0]     res_phandle;
  logic [kgfq_pkg::TIME_W-1:0]       res_ptime;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign ex_fire    = (state_r == ST_EX) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rd_handle = ram_rdata[kgfq_pkg::HANDLE_W-1:0];
  assign rd_time   = ram_rdata[kgfq_pkg::ENTRY_W-1:kgfq_pkg::HANDLE_W];

  always_comb begin
    if (queue_limit > kgfq_pkg::LIMIT_W'(kgfq_pkg::DEPTH)) begin
      cap = kgfq_pkg::CNT_W'(kgfq_pkg::DEPTH);
    end else begin
      cap = kgfq_pkg::CNT_W'(queue_limit);
    end
  end

  assign age  = now_r - rd_time;
  assign aged = (cnt_r != '0) && (now_r >= rd_time) &&
                (age > kgfq_pkg::TIME_W'(max_age_us));

  always_comb begin
    slot_sum = kgfq_pkg::SUM_W'(head_r) + kgfq_pkg::SUM_W'(cnt_r);
    if (key_r) begin
      slot_sum = kgfq_pkg::SUM_W'(head_r);
    end
    if (slot_sum >= kgfq_pkg::SUM_W'(kgfq_pkg::DEPTH)) begin
      slot_sum = slot_sum - kgfq_pkg::SUM_W'(kgfq_pkg::DEPTH);
    end
    slot = slot_sum[kgfq_pkg::PTR_W-1:0];
  end

  always_comb begin
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    wait_nxt    = wait_r;
    push        = 1'b0;
    res_acc     = 1'b0;
    res_drop    = '0;
    res_disc    = 1'b0;
    res_pvalid  = 1'b0;
    res_phandle = '0;
    res_ptime   = '0;
    unique case (kind_r)
      kgfq_pkg::KIND_ENQUEUE: begin
        if (aged) begin
          res_drop = kgfq_pkg::DROP_W'(cnt_r) + kgfq_pkg::DROP_W'(1);
          res_disc = 1'b1;
          cnt_nxt  = '0;
          wait_nxt = 1'b1;
        end else if (wait_r && !key_r) begin
          res_drop = kgfq_pkg::DROP_W'(1);
          res_disc = 1'b1;
        end else if (key_r) begin
          res_drop = kgfq_pkg::DROP_W'(cnt_r);
          cnt_nxt  = kgfq_pkg::CNT_W'(1);
          wait_nxt = 1'b0;
          push     = 1'b1;
          res_acc  = 1'b1;
        end else if (cap == '0 || cnt_r >= cap) begin
          res_drop = kgfq_pkg::DROP_W'(cnt_r) + kgfq_pkg::DROP_W'(1);
          res_disc = 1'b1;
          cnt_nxt  = '0;
          wait_nxt = 1'b1;
        end else begin
          cnt_nxt  = cnt_r + kgfq_pkg::CNT_W'(1);
          push     = 1'b1;
          res_acc  = 1'b1;
        end
      end
      kgfq_pkg::KIND_POP: begin
        if (cnt_r != '0) begin
          res_pvalid  = 1'b1;
          res_phandle = rd_handle;
          res_ptime   = rd_time;
          cnt_nxt     = cnt_r - kgfq_pkg::CNT_W'(1);
          if (head_r == kgfq_pkg::PTR_W'(kgfq_pkg::DEPTH - 1)) begin
            head_nxt = '0;
          end else begin
            head_nxt = head_r + kgfq_pkg::PTR_W'(1);
          end
        end
      end
      kgfq_pkg::KIND_DROP_KEY: begin
        res_drop = kgfq_pkg::DROP_W'(cnt_r);
        cnt_nxt  = '0;
        wait_nxt = 1'b1;
      end
      kgfq_pkg::KIND_RESET: begin
        cnt_nxt  = '0;
        wait_nxt = 1'b1;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_comb begin
    ram_req.we    = ex_fire && push;
    ram_req.waddr = slot;
    ram_req.wdata = {now_r, handle_r};
    ram_req.re    = (state_r == ST_RD);
    ram_req.raddr = head_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_EX;
      end
      ST_EX: begin
        if (ex_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      wait_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ex_fire) begin
        head_r      <= head_nxt;
        cnt_r       <= cnt_nxt;
        wait_r      <= wait_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= in_tuser;
      handle_r <= in_tdata[kgfq_pkg::HANDLE_W-1:0];
      key_r    <= in_tdata[kgfq_pkg::HANDLE_W];
      now_r    <= in_tdata[kgfq_pkg::IN_DATA_W-1:kgfq_pkg::HANDLE_W+kgfq_pkg::FLAGS_W];
    end
    if (ex_fire) begin
      out_data_r <= {res_ptime, res_phandle, res_pvalid, res_disc, res_drop, res_acc};
    end
  end

  `KGFQ_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= kgfq_pkg::CNT_W'(kgfq_pkg::DEPTH))
  `KGFQ_ASSERT_SAME(a_wr_in_ex, clk, rst_n, ram_req.we, state_r == ST_EX)
  `KGFQ_ASSERT_SAME(a_acc_xor_pop, clk, rst_n, out_valid_r, !(out_data_r[0] && out_data_r[7]))
  `KGFQ_ASSERT_NEXT(a_pop_dec, clk, rst_n, ex_fire && res_pvalid,
                    cnt_r == $past(cnt_r) - kgfq_pkg::CNT_W'(1))

endmodule

`default_nettype wire

/* hdl/keyframe_gated_frame_queue_unit.sv */
// ---------------------------------------------------------------------------
// keyframe_gated_frame_queue_unit
// Frame descriptor queue with age flush and key-frame gating.
// ---------------------------------------------------------------------------
// Usage:
//   Each input transaction carries one operation in in_tuser (enqueue, pop,
//   drop until key frame, reset) and the frame handle, flags and current
//   time in in_tdata. Each operation gives exactly one result transaction
//   on the out_ group: accepted, dropped count, discontinuity, and for a pop
//   the oldest handle and its reception time.
//   An accepted operation passes through a read state (oldest entry read from
//   the entry store) and an execute state (write back), and no new operation
//   is taken until it completes. Registers (queue limit, maximum age) are
//   written through cfg_we, cfg_addr and cfg_wdata; the user must write them
//   only while no operation is in flight, as the block does not enforce this.
//   After reset the queue is empty, waits for a key frame and the registers
//   hold their defaults (limit 16, age 100000 us); no clearing pass is run.
//   When out_tready is low the finished result is held in the output
//   register and the next operation waits in the execute step; in_tready
//   stays low until that operation can complete.
// ---------------------------------------------------------------------------
`default_nettype none

module keyframe_gated_frame_queue_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: frame_handle[31:0], frame_flags[39:32], now_us[103:40]
  input  wire logic [kgfq_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: kind[1:0]
  input  wire logic [kgfq_pkg::KIND_W-1:0]       in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_tdata: accepted[0], dropped_count[5:1], discontinuity[6],
  //            pop_valid[7], pop_handle[39:8], pop_time_us[103:40]
  output logic      [kgfq_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_we,
  input  wire logic [kgfq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [kgfq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [kgfq_pkg::LIMIT_W-1:0] queue_limit_r;
  logic [kgfq_pkg::AGE_W-1:0]   max_age_r;
  kgfq_pkg::ram_req_t           ram_req;
  logic [kgfq_pkg::ENTRY_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r <= kgfq_pkg::LIMIT_RST;
      max_age_r     <= kgfq_pkg::AGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        kgfq_pkg::REG_QUEUE_LIMIT: queue_limit_r <= cfg_wdata[kgfq_pkg::LIMIT_W-1:0];
        kgfq_pkg::REG_MAX_AGE:     max_age_r     <= cfg_wdata[kgfq_pkg::AGE_W-1:0];
        default:                   max_age_r     <= max_age_r;
      endcase
    end
  end

  kgfq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .queue_limit (queue_limit_r),
    .max_age_us  (max_age_r),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  kgfq_store_ram #(
    .WIDTH   (kgfq_pkg::ENTRY_W),
    .DEPTH_P (kgfq_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
